FILE: sv/lspg_pkg.sv
// Shared types, constants and color arithmetic for the LED strip pattern generator.
`timescale 1ns / 1ps

package lspg_pkg;

    localparam int C_IDX_W   = 10;   // pixel index
    localparam int C_SPAN_W  = 12;   // span factor, also quotient width
    localparam int C_CNT_W   = 11;   // pixel count
    localparam int C_PROD_W  = C_IDX_W + C_SPAN_W;
    localparam int C_COLOR_W = 24;

    localparam int C_MAX_PIXELS = 1024;

    // register map, index = paddr[3:2]
    localparam logic [1:0] C_REG_MODE  = 2'd0;
    localparam logic [1:0] C_REG_COLOR = 2'd1;
    localparam logic [1:0] C_REG_SPAN  = 2'd2;
    localparam logic [1:0] C_REG_COUNT = 2'd3;

    localparam logic [2:0] C_MODE_RAINBOW = 3'd0;
    localparam logic [2:0] C_MODE_SOLID   = 3'd1;
    localparam logic [2:0] C_MODE_WIPE    = 3'd2;
    localparam logic [2:0] C_MODE_CHASE   = 3'd3;
    localparam logic [2:0] C_MODE_SPARKLE = 3'd4;

    localparam logic C_CMD_PIXEL   = 1'b0;
    localparam logic C_CMD_ADVANCE = 1'b1;

    typedef struct packed {
        logic               command;
        logic [C_IDX_W-1:0] pixel_index;
    } t_pix_req;

    typedef struct packed {
        logic [C_COLOR_W-1:0] pixel_color;
        logic                 index_out_of_range;
    } t_pix_res;

    // x / 255, truncated, exact for x below 65280
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return t[15:8];
    endfunction

    // blue -> green -> red -> blue, 85 positions per segment, 86 in the last
    function automatic logic [23:0] wheel(input logic [7:0] pos);
        logic [7:0] d;
        logic [7:0] r;
        if (pos < 8'd85) begin
            d = pos;
        end else if (pos < 8'd170) begin
            d = pos - 8'd85;
        end else begin
            d = pos - 8'd170;
        end
        r = {d[6:0], 1'b0} + d;
        if (pos < 8'd85) begin
            return {8'h00, r, 8'hff - r};
        end else if (pos < 8'd170) begin
            return {r, 8'hff - r, 8'h00};
        end else begin
            return {8'hff - r, 8'h00, r};
        end
    endfunction

    // index mod 3: base-4 digits each count once since 4 = 1 mod 3
    function automatic logic [1:0] mod3(input logic [C_IDX_W-1:0] v);
        logic [3:0] s;
        logic [2:0] t;
        s = 4'd0;
        for (int k = 0; k < C_IDX_W / 2; k++) begin
            s = s + {2'b00, v[2*k +: 2]};
        end
        t = {1'b0, s[3:2]} + {1'b0, s[1:0]};
        if (t >= 3'd3) begin
            t = t - 3'd3;
        end
        if (t >= 3'd3) begin
            t = t - 3'd3;
        end
        return t[1:0];
    endfunction

endpackage

FILE: sv/lspg_serial_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps

module lspg_serial_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [lspg_pkg::C_PROD_W-1:0] i_dividend,
    input  logic [lspg_pkg::C_CNT_W-1:0]  i_divisor,
    output logic                          o_done,
    output logic [lspg_pkg::C_SPAN_W-1:0] o_quotient
);
    import lspg_pkg::*;

    localparam int C_CNT_BITS = $clog2(C_SPAN_W + 1);

    // dividend < divisor << C_SPAN_W, so the upper part starts below the divisor
    logic [C_CNT_W-1:0]    r_rem,  n_rem;
    logic [C_SPAN_W-1:0]   r_sh,   n_sh;
    logic [C_CNT_W-1:0]    r_dvs;
    logic [C_CNT_BITS-1:0] r_cnt,  n_cnt;
    logic                  r_done, n_done;

    logic [C_CNT_W:0] trial;
    logic [C_CNT_W:0] diff;
    logic             ge;

    assign trial = {r_rem, r_sh[C_SPAN_W-1]};
    assign ge    = trial >= {1'b0, r_dvs};
    assign diff  = trial - {1'b0, r_dvs};

    always_comb begin
        n_rem  = r_rem;
        n_sh   = r_sh;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        if (i_start) begin
            n_rem = C_CNT_W'(i_dividend[C_PROD_W-1:C_SPAN_W]);
            n_sh  = i_dividend[C_SPAN_W-1:0];
            n_cnt = C_CNT_BITS'(C_SPAN_W);
        end else if (r_cnt != '0) begin
            n_rem  = ge ? diff[C_CNT_W-1:0] : trial[C_CNT_W-1:0];
            n_sh   = {r_sh[C_SPAN_W-2:0], ge};
            n_cnt  = r_cnt - 1'b1;
            n_done = (r_cnt == C_CNT_BITS'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_sh  <= n_sh;
        if (i_start) begin
            r_dvs <= i_divisor;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_sh;

endmodule

FILE: sv/led_strip_pattern_generator.sv
// LED strip pattern generator: RGB color of one logical pixel per request, five modes.
// Solid, wipe, chase, spare modes, unlit chase rainbow pixels and out of range requests go
// straight to the finish state; lit chase rainbow pixels pass the wheel and a channel blend,
// rainbow pixels the bit-serial divide by pixel count and the wheel. One request at a time:
// the next goes in the cycle after the result loads; a result not yet taken holds it back.
// Advance requests finish at their accept edge and return nothing.
// Reset (sync, active low) clears frame state and sets mode 0, span 256, count 60.
`timescale 1ns / 1ps

module led_strip_pattern_generator (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // pixel / advance requests
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  lspg_pkg::t_pix_req   i_in_req,
    // pixel colors
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output lspg_pkg::t_pix_res   o_out_res,
    // register port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import lspg_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_WHEEL = 3'd2;
    localparam logic [2:0] S_BLEND = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    // ---------------- configuration registers ----------------
    logic [2:0]           r_mode;
    logic [C_COLOR_W-1:0] r_base_color;
    logic [C_SPAN_W-1:0]  r_span;
    logic [C_CNT_W-1:0]   r_pix_count;
    logic                 cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= C_MODE_RAINBOW;
            r_base_color <= '0;
            r_span       <= C_SPAN_W'(256);
            r_pix_count  <= C_CNT_W'(60);
        end else if (cfg_wr) begin
            case (paddr[3:2])
                C_REG_MODE:  r_mode       <= pwdata[2:0];
                C_REG_COLOR: r_base_color <= pwdata[C_COLOR_W-1:0];
                C_REG_SPAN:  r_span       <= pwdata[C_SPAN_W-1:0];
                C_REG_COUNT: r_pix_count  <= pwdata[C_CNT_W-1:0];
                default:     r_mode       <= r_mode;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            C_REG_MODE:  prdata = {29'd0, r_mode};
            C_REG_COLOR: prdata = {8'd0, r_base_color};
            C_REG_SPAN:  prdata = {20'd0, r_span};
            C_REG_COUNT: prdata = {21'd0, r_pix_count};
            default:     prdata = '0;
        endcase
    end

    // effective count: register capped at the strip maximum; 0 means nothing is in range
    logic [C_CNT_W-1:0] eff_count;
    assign eff_count = (int'(r_pix_count) > C_MAX_PIXELS) ? C_CNT_W'(C_MAX_PIXELS)
                                                          : r_pix_count;

    // ---------------- frame state ----------------
    logic [7:0]         r_rb_off,   n_rb_off;    // rainbow wheel offset
    logic [C_CNT_W-1:0] r_wipe,     n_wipe;      // lit pixels in wipe
    logic [1:0]         r_chase,    n_chase;     // theater chase phase 0..2
    logic [1:0]         r_sp_phase, n_sp_phase;  // chase rainbow phase 0..3
    logic [7:0]         r_sp_off,   n_sp_off;    // chase rainbow wheel offset
    logic [3:0]         r_fade,     n_fade;      // fade step 0..9

    // ---------------- datapath / control ----------------
    logic [2:0]           r_state, n_state;
    logic [7:0]           r_pos,   n_pos;     // wheel position
    logic [7:0]           r_ratio, n_ratio;   // blend scale per channel
    logic                 r_blend, n_blend;   // wheel color gets scaled
    logic [C_COLOR_W-1:0] r_color, n_color;   // result shift register, one byte per step
    logic                 r_oor,   n_oor;
    logic [1:0]           r_chan,  n_chan;    // blend channel counter
    logic                 r_out_valid;
    t_pix_res             r_out_res;

    logic                 in_fire;
    logic                 req_oor;
    logic                 div_start;
    logic                 div_done;
    logic [C_SPAN_W-1:0]  div_quo;
    logic [C_PROD_W-1:0]  span_prod;
    logic [8:0]           fade_x25;
    logic [7:0]           fade_ratio;
    logic [C_IDX_W-1:0]   idx;
    logic [1:0]           idx_p1;
    logic [15:0]          chan_prod;
    logic                 out_load;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid & o_in_ready;
    assign idx        = i_in_req.pixel_index;
    assign idx_p1     = idx[1:0] + 2'd1;
    assign req_oor    = {1'b0, idx} >= eff_count;

    // index * span, quotient by count is below span since index < count
    assign span_prod  = C_PROD_W'(idx) * C_PROD_W'(r_span);
    assign fade_x25   = {5'd0, r_fade} * 9'd25;
    assign fade_ratio = fade_x25[7:0];

    // blend step on the low byte: c * ratio / 255
    assign chan_prod  = {8'd0, r_color[7:0]} * {8'd0, r_ratio};

    always_comb begin
        n_state    = r_state;
        n_pos      = r_pos;
        n_ratio    = r_ratio;
        n_blend    = r_blend;
        n_color    = r_color;
        n_oor      = r_oor;
        n_chan     = r_chan;
        n_rb_off   = r_rb_off;
        n_wipe     = r_wipe;
        n_chase    = r_chase;
        n_sp_phase = r_sp_phase;
        n_sp_off   = r_sp_off;
        n_fade     = r_fade;
        div_start  = 1'b0;
        out_load   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_in_req.command == C_CMD_ADVANCE) begin
                        // frame step, no result
                        case (r_mode)
                            C_MODE_RAINBOW: n_rb_off = r_rb_off + 8'd1;
                            C_MODE_WIPE: begin
                                n_wipe = (r_wipe >= eff_count) ? '0 : r_wipe + 1'b1;
                            end
                            C_MODE_CHASE: n_chase = (r_chase >= 2'd2) ? 2'd0 : r_chase + 2'd1;
                            C_MODE_SPARKLE: begin
                                if (r_fade >= 4'd9) begin
                                    n_fade     = 4'd0;
                                    n_sp_phase = r_sp_phase + 2'd1;
                                    n_sp_off   = r_sp_off + 8'd10;
                                end else begin
                                    n_fade = r_fade + 4'd1;
                                end
                            end
                            default: n_fade = r_fade;
                        endcase
                    end else if (req_oor) begin
                        n_color = '0;
                        n_oor   = 1'b1;
                        n_state = S_FIN;
                    end else begin
                        n_oor   = 1'b0;
                        n_color = '0;
                        n_state = S_FIN;
                        case (r_mode)
                            C_MODE_RAINBOW: begin
                                div_start = 1'b1;
                                n_state   = S_DIV;
                            end
                            C_MODE_SOLID: n_color = r_base_color;
                            C_MODE_WIPE: begin
                                n_color = ({1'b0, idx} < r_wipe) ? r_base_color : '0;
                            end
                            C_MODE_CHASE: begin
                                n_color = (mod3(idx) == r_chase) ? r_base_color : '0;
                            end
                            C_MODE_SPARKLE: begin
                                // lit pixel fades in, the one before it fades out
                                if (idx[1:0] == r_sp_phase) begin
                                    n_pos   = idx[7:0] + r_sp_off;
                                    n_ratio = fade_ratio;
                                    n_blend = 1'b1;
                                    n_state = S_WHEEL;
                                end else if (idx_p1 == r_sp_phase) begin
                                    n_pos   = idx[7:0] + 8'd1 + r_sp_off;
                                    n_ratio = 8'hff - fade_ratio;
                                    n_blend = 1'b1;
                                    n_state = S_WHEEL;
                                end
                            end
                            default: n_color = '0;
                        endcase
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_pos   = div_quo[7:0] + r_rb_off;
                    n_blend = 1'b0;
                    n_state = S_WHEEL;
                end
            end
            S_WHEEL: begin
                n_color = wheel(r_pos);
                n_chan  = 2'd0;
                n_state = r_blend ? S_BLEND : S_FIN;
            end
            S_BLEND: begin
                // rotate right a byte per step: after three steps order is restored
                n_color = {div255(chan_prod), r_color[C_COLOR_W-1:8]};
                n_chan  = r_chan + 2'd1;
                if (r_chan == 2'd2) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    lspg_serial_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (span_prod),
        .i_divisor  (eff_count),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rb_off    <= '0;
            r_wipe      <= '0;
            r_chase     <= '0;
            r_sp_phase  <= '0;
            r_sp_off    <= '0;
            r_fade      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rb_off   <= n_rb_off;
            r_wipe     <= n_wipe;
            r_chase    <= n_chase;
            r_sp_phase <= n_sp_phase;
            r_sp_off   <= n_sp_off;
            r_fade     <= n_fade;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos   <= n_pos;
        r_ratio <= n_ratio;
        r_blend <= n_blend;
        r_color <= n_color;
        r_oor   <= n_oor;
        r_chan  <= n_chan;
        if (out_load) begin
            r_out_res <= '{pixel_color: r_color, index_out_of_range: r_oor};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out_res;

    // ---------------- checks ----------------
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_DIV)
        else $error("divider finished outside the divide state");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_FIN)
        else $error("result loaded outside the finish state");

    a_oor_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_res.index_out_of_range |-> o_out_res.pixel_color == '0)
        else $error("out of range result carries a color");

    a_chase_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chase != 2'd3 && r_fade <= 4'd9)
        else $error("frame phase left its range");

endmodule

FILE: sim/led_strip_pattern_generator_tb.sv
// Self-checking testbench for the LED strip pattern generator: random requests, color model.
`timescale 1ns / 1ps
module led_strip_pattern_generator_tb;
    import lspg_pkg::*;

    // modes 5..7 have no pattern behind them
    localparam logic [2:0] C_MODE_SPARE_LO = 3'd5;
    localparam logic [2:0] C_MODE_SPARE_HI = 3'd7;
    // drain time after the last result
    localparam int C_DRAIN_CYCLES = 20;
    localparam int C_RAND_PHASES  = 16;
    localparam int C_PHASE_ITEMS  = 25;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    t_pix_req    i_in_req    = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_pix_res    o_out_res;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [3:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;

    led_strip_pattern_generator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_res   (o_out_res),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow of the block: register copies and per-mode frame state
    // ------------------------------------------------------------------
    logic [2:0]  cfg_mode;
    logic [23:0] cfg_color;
    logic [11:0] cfg_span;
    logic [10:0] cfg_count;

    logic [7:0]  rb_offset;     // rainbow wheel offset
    logic [10:0] wipe_lit;      // lit pixels in wipe
    logic [1:0]  chase_ph;      // lit phase of theater chase
    logic [1:0]  spark_ph;      // lit phase of chase rainbow
    logic [7:0]  spark_off;     // wheel offset of chase rainbow
    logic [3:0]  fade_cnt;      // fade step, 0..9

    t_pix_res    expected_colors[$];
    t_pix_res    due;

    int n_colors = 0;
    int n_oor    = 0;
    int n_adv    = 0;
    int n_writes = 0;
    int n_errors = 0;

    function automatic int eff_count();
        return (cfg_count > 11'd1024) ? 1024 : int'(cfg_count);
    endfunction

    // per-channel (a*(255-r) + b*r) / 255, truncated
    function automatic logic [23:0] blend(input logic [23:0] a, input logic [23:0] b,
                                          input int ratio);
        logic [23:0] acc;
        int          ca;
        int          cb;
        int          r;
        acc = '0;
        r   = ratio & 255;
        for (int sh = 0; sh < 24; sh += 8) begin
            ca = int'(a[sh +: 8]);
            cb = int'(b[sh +: 8]);
            acc[sh +: 8] = 8'((ca * (255 - r) + cb * r) / 255);
        end
        return acc;
    endfunction

    // blue -> green -> red -> blue
    function automatic logic [23:0] wheel_rgb(input logic [7:0] pos);
        int p;
        p = int'(pos);
        if (p < 85) begin
            return blend(24'h0000ff, 24'h00ff00, p * 3);
        end else if (p < 170) begin
            return blend(24'h00ff00, 24'hff0000, (p - 85) * 3);
        end
        return blend(24'hff0000, 24'h0000ff, (p - 170) * 3);
    endfunction

    function automatic t_pix_res predict_pixel(input logic [C_IDX_W-1:0] idx);
        t_pix_res res;
        int       cnt;
        int       i;
        int       r;
        cnt = eff_count();
        i   = int'(idx);
        res.pixel_color        = '0;
        res.index_out_of_range = 1'b0;
        if (i >= cnt) begin
            // also covers a count of zero
            res.index_out_of_range = 1'b1;
            return res;
        end
        case (cfg_mode)
            C_MODE_RAINBOW: begin
                res.pixel_color = wheel_rgb(8'((i * int'(cfg_span)) / cnt + int'(rb_offset)));
            end
            C_MODE_SOLID: begin
                res.pixel_color = cfg_color;
            end
            C_MODE_WIPE: begin
                res.pixel_color = (i < int'(wipe_lit)) ? cfg_color : 24'h0;
            end
            C_MODE_CHASE: begin
                res.pixel_color = ((i % 3) == int'(chase_ph)) ? cfg_color : 24'h0;
            end
            C_MODE_SPARKLE: begin
                r = int'(fade_cnt) * 25;
                if ((i & 3) == int'(spark_ph)) begin
                    // fading in
                    res.pixel_color = blend(24'h0, wheel_rgb(8'(i + int'(spark_off))), r);
                end else if (((i + 1) & 3) == int'(spark_ph)) begin
                    // trailing neighbor fading out
                    res.pixel_color = blend(wheel_rgb(8'(i + 1 + int'(spark_off))), 24'h0, r);
                end
            end
            default: begin
                res.pixel_color = '0;
            end
        endcase
        return res;
    endfunction

    function automatic void step_frame();
        int cnt;
        cnt = eff_count();
        case (cfg_mode)
            C_MODE_RAINBOW: rb_offset = rb_offset + 8'd1;
            // overshoot after a lowered count falls back to zero
            C_MODE_WIPE:    wipe_lit = (int'(wipe_lit) >= cnt) ? 11'd0 : wipe_lit + 11'd1;
            C_MODE_CHASE:   chase_ph = (chase_ph >= 2'd2) ? 2'd0 : chase_ph + 2'd1;
            C_MODE_SPARKLE: begin
                if (fade_cnt >= 4'd9) begin
                    fade_cnt  = 4'd0;
                    spark_ph  = spark_ph + 2'd1;
                    spark_off = spark_off + 8'd10;
                end else begin
                    fade_cnt = fade_cnt + 4'd1;
                end
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Request driver: pops the backlog, random gap after each request
    // ------------------------------------------------------------------
    t_pix_req    req_backlog[$];
    int unsigned req_gap  = 0;
    bit          tx_burst = 1'b0;
    bit          rx_burst = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            req_gap    <= 0;
        end else if (!i_in_valid || o_in_ready) begin
            // slot is free: nothing shown, or the shown request goes in now
            if (req_gap != 0) begin
                i_in_valid <= 1'b0;
                req_gap    <= req_gap - 1;
            end else if (req_backlog.size() != 0) begin
                i_in_req   <= req_backlog.pop_front();
                i_in_valid <= 1'b1;
                req_gap    <= tx_burst ? 0 : $urandom_range(0, 7);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side backpressure: random stall after each result
    // ------------------------------------------------------------------
    int unsigned res_stall  = 0;
    int unsigned stall_draw = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            res_stall   <= 0;
        end else if (res_stall != 0) begin
            res_stall   <= res_stall - 1;
            i_out_ready <= (res_stall == 1);
        end else if (o_out_valid && i_out_ready) begin
            stall_draw = rx_burst ? 0 : $urandom_range(0, 7);
            res_stall   <= stall_draw;
            i_out_ready <= (stall_draw == 0);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: tracks register writes, predicts on accept, checks results
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_mode  = C_MODE_RAINBOW;
            cfg_color = '0;
            cfg_span  = 12'd256;
            cfg_count = 11'd60;
            rb_offset = '0;
            wipe_lit  = '0;
            chase_ph  = '0;
            spark_ph  = '0;
            spark_off = '0;
            fade_cnt  = '0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                // bits above each register's width are dropped
                case (paddr[3:2])
                    C_REG_MODE:  cfg_mode  = pwdata[2:0];
                    C_REG_COLOR: cfg_color = pwdata[23:0];
                    C_REG_SPAN:  cfg_span  = pwdata[11:0];
                    C_REG_COUNT: cfg_count = pwdata[10:0];
                    default:     ;
                endcase
                n_writes++;
            end
            // check before predicting: a result leaving now belongs to an older request
            if (o_out_valid && i_out_ready) begin
                if (expected_colors.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got color %h oor %b",
                             $time, o_out_res.pixel_color, o_out_res.index_out_of_range);
                    n_errors++;
                end else begin
                    due = expected_colors.pop_front();
                    if (o_out_res.pixel_color !== due.pixel_color) begin
                        $display("%0t: pixel_color mismatch, expected %h, got %h",
                                 $time, due.pixel_color, o_out_res.pixel_color);
                        n_errors++;
                    end
                    if (o_out_res.index_out_of_range !== due.index_out_of_range) begin
                        $display("%0t: index_out_of_range mismatch, expected %b, got %b",
                                 $time, due.index_out_of_range, o_out_res.index_out_of_range);
                        n_errors++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                if (i_in_req.command == C_CMD_ADVANCE) begin
                    step_frame();
                    n_adv++;
                end else begin
                    due = predict_pixel(i_in_req.pixel_index);
                    expected_colors.push_back(due);
                    n_colors++;
                    if (due.index_out_of_range) begin
                        n_oor++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic push_item(input logic cmd, input logic [C_IDX_W-1:0] idx);
        t_pix_req item;
        item.command     = cmd;
        item.pixel_index = idx;
        req_backlog.push_back(item);
    endtask

    // hold off until every request went in and every result came back
    task automatic settle();
        do begin
            @(posedge i_clk);
            #1;
        end while (req_backlog.size() != 0 || i_in_valid || expected_colors.size() != 0);
        repeat (C_DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // half of the time, garbage above the register width
    function automatic logic [31:0] with_junk(input logic [31:0] value, input logic [31:0] keep);
        if ($urandom_range(0, 1) == 0) begin
            return value & keep;
        end
        return (value & keep) | ($urandom & ~keep);
    endfunction

    initial begin : stimulus
        int          eff_cnt;
        int unsigned m;
        int unsigned v;

        eff_cnt = 60;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: rainbow, span 256, count 60
        push_item(C_CMD_PIXEL, 10'd0);
        push_item(C_CMD_PIXEL, 10'd59);
        push_item(C_CMD_PIXEL, 10'd60);      // first index out of range
        push_item(C_CMD_PIXEL, 10'd1023);
        push_item(C_CMD_ADVANCE, 10'd0);
        push_item(C_CMD_PIXEL, 10'd59);
        settle();

        // all-ones writes: span 4095, count 2047 capped at the max strip length
        write_reg(C_REG_SPAN, 32'hffff_ffff);
        write_reg(C_REG_COUNT, 32'hffff_ffff);
        push_item(C_CMD_PIXEL, 10'd1023);
        settle();

        // solid white, upper junk in the color write; empty strip
        write_reg(C_REG_MODE, 32'(C_MODE_SOLID));
        write_reg(C_REG_COLOR, 32'ha5ff_ffff);
        write_reg(C_REG_COUNT, 32'd0);
        push_item(C_CMD_PIXEL, 10'd0);
        settle();
        write_reg(C_REG_COUNT, 32'd1);
        push_item(C_CMD_PIXEL, 10'd0);
        settle();

        // wipe, then lower the count below the lit length
        write_reg(C_REG_MODE, 32'(C_MODE_WIPE));
        write_reg(C_REG_COUNT, 32'd2);
        push_item(C_CMD_ADVANCE, 10'd0);
        push_item(C_CMD_ADVANCE, 10'd0);
        push_item(C_CMD_PIXEL, 10'd1);
        settle();
        write_reg(C_REG_COUNT, 32'd1);
        push_item(C_CMD_ADVANCE, 10'd0);
        push_item(C_CMD_PIXEL, 10'd0);
        settle();

        // theater chase through phase 2 and its wrap
        write_reg(C_REG_MODE, 32'(C_MODE_CHASE));
        write_reg(C_REG_COUNT, 32'd60);
        push_item(C_CMD_ADVANCE, 10'd0);
        push_item(C_CMD_ADVANCE, 10'd0);
        push_item(C_CMD_PIXEL, 10'd2);
        push_item(C_CMD_ADVANCE, 10'd0);
        push_item(C_CMD_PIXEL, 10'd0);
        settle();

        // chase rainbow: lit pixel and its trailing neighbor
        write_reg(C_REG_MODE, 32'(C_MODE_SPARKLE));
        push_item(C_CMD_ADVANCE, 10'd0);
        push_item(C_CMD_PIXEL, 10'd0);
        push_item(C_CMD_PIXEL, 10'd3);
        settle();

        // spare mode: black, advance is a no-op
        write_reg(C_REG_MODE, 32'(C_MODE_SPARE_HI));
        push_item(C_CMD_PIXEL, 10'd0);
        push_item(C_CMD_ADVANCE, 10'd0);
        settle();

        // random phases; frame state carries over between them
        for (int ph = 0; ph < C_RAND_PHASES; ph++) begin
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0) begin
                m = $urandom_range(C_MODE_SPARE_LO, C_MODE_SPARE_HI);
            end else begin
                m = $urandom_range(C_MODE_RAINBOW, C_MODE_SPARKLE);
            end
            write_reg(C_REG_MODE, with_junk(m, 32'h7));
            if ($urandom_range(0, 1) == 1) begin
                write_reg(C_REG_COLOR, with_junk($urandom, 32'hff_ffff));
            end
            if ($urandom_range(0, 1) == 1) begin
                case ($urandom_range(0, 5))
                    0:       v = 0;
                    1:       v = 4095;
                    default: v = $urandom_range(0, 4095);
                endcase
                write_reg(C_REG_SPAN, with_junk(v, 32'hfff));
            end
            if ($urandom_range(0, 1) == 1) begin
                // mostly short strips
                case ($urandom_range(0, 9))
                    0:       v = 0;
                    1:       v = 1;
                    2:       v = 1024;
                    3:       v = $urandom_range(1025, 2047);
                    default: v = $urandom_range(2, 64);
                endcase
                write_reg(C_REG_COUNT, with_junk(v, 32'h7ff));
                eff_cnt = (v > 1024) ? 1024 : int'(v);
            end
            repeat (C_PHASE_ITEMS) begin
                if ($urandom_range(0, 99) < 35) begin
                    push_item(C_CMD_ADVANCE, 10'($urandom));
                end else if (eff_cnt > 0 && $urandom_range(0, 3) != 0) begin
                    push_item(C_CMD_PIXEL, 10'($urandom_range(0, eff_cnt - 1)));
                end else begin
                    push_item(C_CMD_PIXEL, 10'($urandom));
                end
            end
            settle();
        end

        $display("covered %0d color requests (%0d out of range) and %0d frame advances",
                 n_colors, n_oor, n_adv);
        $display("across %0d register writes in all five modes and the spare modes", n_writes);
        if (n_errors == 0) begin
            $display("led_strip_pattern_generator_tb: PASS");
        end else begin
            $display("led_strip_pattern_generator_tb: FAIL");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("led_strip_pattern_generator_tb: FAIL");
        $finish;
    end

endmodule

FILE: sim.f
sv/lspg_pkg.sv
sv/lspg_serial_div.sv
sv/led_strip_pattern_generator.sv
sim/led_strip_pattern_generator_tb.sv
